[sv/gesi_pkg.sv]
package gesi_pkg;

  // Default sizes of the stores
  localparam int MAX_ENTITIES_DEF = 1024;
  localparam int MAX_GROUPS_DEF   = 64;

  // Field widths
  localparam int GRP_W    = 6;
  localparam int WORD_W   = 64;
  localparam int SLOT_W   = 10;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 11;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 80;
  localparam int ENT_RAM_W  = GRP_W + WORD_W;

  // Actions
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_GROUP = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic cfg_wr;
    logic init_step;
    logic rd_slot;
    logic rd_meta_g;
    logic cap_g;
    logic rd_meta_gi;
    logic cap_gi;
    logic move_step;
    logic gi_dec;
    logic finish_add;
    logic res_range;
    logic res_bad;
    logic res_full;
    logic res_read;
  } gesi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic slot_ok;
    logic bad_group;
    logic full;
    logic cfg_grow;
    logic init_last;
    logic gi_above;
    logic j_nz;
  } gesi_sts_t;

endpackage

[sv/gesi_ram.sv]
module gesi_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                      wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                      rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[sv/gesi_ctrl.sv]
module gesi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  gesi_pkg::gesi_sts_t sts_i,
  output gesi_pkg::gesi_cmd_t cmd_o
);
  import gesi_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_RD_WAIT = 4'd3;
  localparam logic [3:0] S_G_WAIT  = 4'd4;
  localparam logic [3:0] S_GRP     = 4'd5;
  localparam logic [3:0] S_GI_WAIT = 4'd6;
  localparam logic [3:0] S_MOVE    = 4'd7;
  localparam logic [3:0] S_FINAL   = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       cfg_fire, in_fire;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;

  // Sequence one item at a time
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          cmd_o.cfg_wr = 1'b1;
          if (sts_i.cfg_grow) state_d = S_INIT;
        end else if (in_fire) begin
          cmd_o.accept = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_DECODE: begin
        priority if (sts_i.is_read && sts_i.slot_ok) begin
          cmd_o.rd_slot = 1'b1;
          state_d = S_RD_WAIT;
        end else if (sts_i.is_read) begin
          cmd_o.res_range = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.bad_group) begin
          cmd_o.res_bad = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.full) begin
          cmd_o.res_full = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.rd_meta_g = 1'b1;
          state_d = S_G_WAIT;
        end
      end
      S_RD_WAIT: begin
        cmd_o.res_read = 1'b1;
        state_d = S_OUT;
      end
      S_G_WAIT: begin
        cmd_o.cap_g = 1'b1;
        state_d = S_GRP;
      end
      S_GRP: begin
        if (sts_i.gi_above) begin
          cmd_o.rd_meta_gi = 1'b1;
          state_d = S_GI_WAIT;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_GI_WAIT: begin
        cmd_o.cap_gi = 1'b1;
        state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (!sts_i.j_nz) begin
          cmd_o.gi_dec = 1'b1;
          state_d = S_GRP;
        end
      end
      S_FINAL: begin
        cmd_o.finish_add = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Input and output sides never open together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input ready while result pending");

  // An accepted beat is decoded next
  a_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_DECODE) else $error("accepted beat not decoded");

  // A drained group returns to the group loop
  a_move_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE && !sts_i.j_nz) |=> state_q == S_GRP)
    else $error("move loop did not exit");
endmodule

[sv/gesi_dpath.sv]
module gesi_dpath #(
  parameter int MAX_ENTITIES = gesi_pkg::MAX_ENTITIES_DEF,
  parameter int MAX_GROUPS   = gesi_pkg::MAX_GROUPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gesi_pkg::gesi_cmd_t                 cmd_i,
  output gesi_pkg::gesi_sts_t                 sts_o,
  input  logic [gesi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gesi_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                action_i,
  input  logic [gesi_pkg::GRP_W-1:0]          group_index_i,
  input  logic [gesi_pkg::WORD_W-1:0]         entity_word_i,
  input  logic [gesi_pkg::SLOT_W-1:0]         slot_index_i,
  output logic [gesi_pkg::STAT_W-1:0]         status_o,
  output logic [gesi_pkg::SLOT_W-1:0]         slot_o,
  output logic [gesi_pkg::WORD_W-1:0]         stored_word_o,
  output logic [gesi_pkg::GRP_W-1:0]          owner_group_o
);
  import gesi_pkg::*;

  localparam int SW  = $clog2(MAX_ENTITIES);
  localparam int CW  = $clog2(MAX_ENTITIES + 1);
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GCW = $clog2(MAX_GROUPS + 1);
  localparam int MW  = 2 * CW;

  // Item and configuration registers
  logic              act_q;
  logic [GRP_W-1:0]  grp_q;
  logic [WORD_W-1:0] word_q;
  logic [SLOT_W-1:0] sidx_q;
  logic [GCW-1:0]    giu_q, giu_d;
  logic [CW-1:0]     lim_q, lim_d;
  logic [CW-1:0]     total_q;

  // Insert sequencing registers
  logic [CW-1:0]     pos_q, gstart_q, gsize_q;
  logic [GW-1:0]     gi_q;
  logic [CW-1:0]     base_q, j_q;
  logic              pend_q;
  logic [CW-1:0]     dst_q;
  logic [GCW-1:0]    init_k_q, init_end_q;

  // Result registers
  logic [STAT_W-1:0] st_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WORD_W-1:0] sword_q;
  logic [GRP_W-1:0]  own_q;

  // Memory ports
  logic                 ent_we, meta_we;
  logic [SW-1:0]        ent_waddr, ent_raddr;
  logic [ENT_RAM_W-1:0] ent_wdata, ent_rdata;
  logic [GW-1:0]        meta_waddr, meta_raddr;
  logic [MW-1:0]        meta_wdata, meta_rdata;
  logic [CW-1:0]        m_start, m_size, src;

  assign m_start = meta_rdata[MW-1:CW];
  assign m_size  = meta_rdata[CW-1:0];
  assign src     = CW'(base_q + j_q - 1'b1);

  // Clamp configuration values
  always_comb begin
    if (32'(cfg_data_i[6:0]) > MAX_GROUPS) giu_d = GCW'(MAX_GROUPS);
    else giu_d = GCW'(cfg_data_i[6:0]);
    if (32'(cfg_data_i) > MAX_ENTITIES) lim_d = CW'(MAX_ENTITIES);
    else lim_d = CW'(cfg_data_i);
  end

  // Status toward the controller
  always_comb begin
    sts_o.is_read   = (act_q == ACT_READ);
    sts_o.slot_ok   = 32'(sidx_q) < 32'(total_q);
    sts_o.bad_group = 32'(grp_q) >= 32'(giu_q);
    sts_o.full      = total_q >= lim_q;
    sts_o.cfg_grow  = (cfg_index_i == CFG_GROUPS) && (giu_d > giu_q);
    sts_o.init_last = GCW'(init_k_q + 1'b1) == init_end_q;
    sts_o.gi_above  = 32'(gi_q) > 32'(grp_q);
    sts_o.j_nz      = (j_q != '0);
  end

  // Memory address and data selection
  always_comb begin
    ent_raddr  = cmd_i.rd_slot ? SW'(sidx_q) : SW'(src);
    meta_raddr = cmd_i.rd_meta_g ? GW'(grp_q) : gi_q;
    ent_we     = 1'b0;
    ent_waddr  = SW'(dst_q);
    ent_wdata  = {GRP_W'(gi_q), ent_rdata[WORD_W-1:0]};
    meta_we    = 1'b0;
    meta_waddr = gi_q;
    meta_wdata = {CW'(m_start + 1'b1), m_size};
    if (cmd_i.move_step && pend_q && 32'(dst_q) < MAX_ENTITIES) begin
      ent_we = 1'b1;
    end
    if (cmd_i.finish_add) begin
      ent_we     = 32'(pos_q) < MAX_ENTITIES;
      ent_waddr  = SW'(pos_q);
      ent_wdata  = {grp_q, word_q};
      meta_we    = 1'b1;
      meta_waddr = GW'(grp_q);
      meta_wdata = {gstart_q, CW'(gsize_q + 1'b1)};
    end else if (cmd_i.cap_gi) begin
      meta_we = 1'b1;
    end else if (cmd_i.init_step) begin
      meta_we    = 1'b1;
      meta_waddr = GW'(init_k_q);
      meta_wdata = {total_q, CW'(0)};
    end
  end

  gesi_ram #(.W(ENT_RAM_W), .D(MAX_ENTITIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  gesi_ram #(.W(MW), .D(MAX_GROUPS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // Control state: configuration, total, move pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      giu_q   <= '0;
      lim_q   <= CW'(MAX_ENTITIES > 1024 ? 1024 : MAX_ENTITIES);
      total_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr && cfg_index_i == CFG_GROUPS) giu_q <= giu_d;
      if (cmd_i.cfg_wr && cfg_index_i == CFG_LIMIT)  lim_q <= lim_d;
      if (cmd_i.finish_add) total_q <= CW'(total_q + 1'b1);
      if (cmd_i.move_step) pend_q <= (j_q != '0);
    end
  end

  // Payload and loop registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= action_i;
      grp_q  <= group_index_i;
      word_q <= entity_word_i;
      sidx_q <= slot_index_i;
    end
    if (cmd_i.cfg_wr) begin
      init_k_q   <= giu_q;
      init_end_q <= giu_d;
    end else if (cmd_i.init_step) begin
      init_k_q <= GCW'(init_k_q + 1'b1);
    end
    if (cmd_i.cap_g) begin
      pos_q    <= CW'(m_start + m_size);
      gstart_q <= m_start;
      gsize_q  <= m_size;
      gi_q     <= GW'(giu_q - 1'b1);
    end
    if (cmd_i.cap_gi) begin
      base_q <= m_start;
      j_q    <= m_size;
    end
    if (cmd_i.move_step && j_q != '0) begin
      dst_q <= CW'(base_q + j_q);
      j_q   <= CW'(j_q - 1'b1);
    end
    if (cmd_i.gi_dec) gi_q <= GW'(gi_q - 1'b1);
    // Result capture
    if (cmd_i.res_range) begin
      st_q <= ST_RANGE; slot_q <= sidx_q; sword_q <= '0; own_q <= '0;
    end
    if (cmd_i.res_bad) begin
      st_q <= ST_BAD_GROUP; slot_q <= '0; sword_q <= '0; own_q <= '0;
    end
    if (cmd_i.res_full) begin
      st_q <= ST_FULL; slot_q <= '0; sword_q <= '0; own_q <= '0;
    end
    if (cmd_i.res_read) begin
      st_q    <= ST_OK;
      slot_q  <= sidx_q;
      sword_q <= ent_rdata[WORD_W-1:0];
      own_q   <= ent_rdata[ENT_RAM_W-1:WORD_W];
    end
    if (cmd_i.finish_add) begin
      st_q <= ST_OK; slot_q <= SLOT_W'(pos_q); sword_q <= '0; own_q <= grp_q;
    end
  end

  assign status_o      = st_q;
  assign slot_o        = slot_q;
  assign stored_word_o = sword_q;
  assign owner_group_o = own_q;

  // Total never passes the store depth
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MAX_ENTITIES) else $error("total beyond store depth");

  // Limit never passes the store depth
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lim_q) <= MAX_ENTITIES) else $error("limit beyond store depth");

  // Adds only complete below the limit
  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_add |-> total_q < lim_q) else $error("add past limit");
endmodule

[sv/grouped_entity_store_insert.sv]
// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser action; tdata group, word, slot
// m_axis   | out | m_axis_tvalid/m_axis_tready  | tuser status; tdata slot, word, owner
// cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One item at a time. A read passes decode and an entity memory read; a refused
// add or an out-of-range read ends at decode. An add shifts each later live
// group up one slot, one move per cycle through the single read and write port
// of the entity memory, then writes the new entity at the end of its group.
// Raising groups_in_use sweeps the new group entries, one per cycle, with
// both input ports held off. Reset clears state, group count and total and presets the limit only.
// A stalled result holds the block; the next beat is taken once it leaves.
module grouped_entity_store_insert #(
  parameter int MAX_ENTITIES = gesi_pkg::MAX_ENTITIES_DEF,
  parameter int MAX_GROUPS   = gesi_pkg::MAX_GROUPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gesi_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // group_index, entity_word, slot_index
  input  logic                              s_axis_tuser,  // action
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gesi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // slot, stored_word, owner_group
  output logic [gesi_pkg::STAT_W-1:0]       m_axis_tuser,  // status
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gesi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gesi_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import gesi_pkg::*;

  gesi_cmd_t         cmd;
  gesi_sts_t         sts;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] sword;
  logic [GRP_W-1:0]  owner;

  gesi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gesi_dpath #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .MAX_GROUPS   (MAX_GROUPS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .action_i      (s_axis_tuser),
    .group_index_i (s_axis_tdata[5:0]),
    .entity_word_i (s_axis_tdata[69:6]),
    .slot_index_i  (s_axis_tdata[79:70]),
    .status_o      (m_axis_tuser),
    .slot_o        (slot),
    .stored_word_o (sword),
    .owner_group_o (owner)
  );

  assign m_axis_tdata = {owner, sword, slot};
endmodule
